### sv/g3r_pkg.sv
// Shared types, constants and shaping table for the G3RUH NRZI shaped modulator.
package g3r_pkg;

  localparam int unsigned BYTE_W          = 8;
  localparam int unsigned SAMPLE_W        = 8;
  localparam int unsigned SAMPLES_PER_BIT = 8;
  localparam int unsigned BITS_PER_BYTE   = 8;
  localparam int unsigned SAMPLES_PER_BYTE = SAMPLES_PER_BIT * BITS_PER_BYTE;
  localparam int unsigned CNT_W           = $clog2(SAMPLES_PER_BYTE);
  localparam int unsigned COL_W           = $clog2(SAMPLES_PER_BIT);
  localparam int unsigned ROW_W           = 3;
  localparam int unsigned HIST_W          = 16;

  localparam logic [HIST_W-1:0] SEED_HISTORY = 16'h1000;
  localparam logic              SEED_OLD_BIT = 1'b1;
  localparam int unsigned       TAP_SHORT    = 11;
  localparam int unsigned       TAP_LONG     = 15;

  localparam logic [CNT_W-1:0] LAST_SAMPLE = CNT_W'(SAMPLES_PER_BYTE - 1);
  localparam logic [COL_W-1:0] LAST_COL    = COL_W'(SAMPLES_PER_BIT - 1);

  // Rows are selected by the last three line levels, oldest in the top bit.
  localparam logic [SAMPLE_W-1:0] SHAPE_TABLE [0:7][0:7] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd0,   8'd2,   8'd6,   8'd18,  8'd42,  8'd80 },
    '{8'd127, 8'd175, 8'd212, 8'd235, 8'd243, 8'd235, 8'd212, 8'd175},
    '{8'd128, 8'd175, 8'd213, 8'd237, 8'd249, 8'd253, 8'd255, 8'd255},
    '{8'd127, 8'd80,  8'd42,  8'd18,  8'd6,   8'd2,   8'd0,   8'd0  },
    '{8'd128, 8'd80,  8'd43,  8'd20,  8'd12,  8'd20,  8'd43,  8'd80 },
    '{8'd255, 8'd255, 8'd255, 8'd253, 8'd249, 8'd237, 8'd213, 8'd175},
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}
  };

  // Control from the sequencer to the scrambler and line coder.
  typedef struct packed {
    logic step;      // advance by one bit
    logic seed;      // reload scrambler seed before this bit
    logic data_bit;  // plain data bit
  } g3r_bit_ctrl_t;

  function automatic logic [SAMPLE_W-1:0] shape_sample(input logic [ROW_W-1:0] row,
                                                       input logic [COL_W-1:0] col);
    return SHAPE_TABLE[row][col];
  endfunction

endpackage

### sv/g3r_if.sv
// Valid/ready channel interfaces for byte input and sample output.
interface g3r_in_if;
  import g3r_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              frame_start;
  logic              frame_last;

  modport source (output valid, output data_byte, output frame_start, output frame_last,
                  input ready);
  modport sink   (input valid, input data_byte, input frame_start, input frame_last,
                  output ready);
endinterface

interface g3r_out_if;
  import g3r_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                run_last;
  logic                frame_done;

  modport source (output valid, output sample, output run_last, output frame_done,
                  input ready);
  modport sink   (input valid, input sample, input run_last, input frame_done,
                  output ready);
endinterface

### sv/g3ruh_nrzi_shaped_modulator_top.sv
// Top level of the G3RUH scrambled NRZI modulator with shaped DAC samples.
//
//  channel  | dir | payload                              | transaction
//  ---------+-----+--------------------------------------+-------------------------
//  in_ch    | in  | data_byte[7:0] frame_start frame_last| one byte, MSB sent first
//  out_ch   | out | sample[7:0] run_last frame_done      | one DAC sample
//
// Each byte gives 64 output transactions, one per cycle when out_ch is not
// stalled; the sample counter sets that figure. The next byte is taken in the
// cycle the 64th sample enters the output register, so bytes follow with no gap.
// Reset (rst, synchronous) loads the scrambler seed, clears the line level,
// the level history, the busy flag and the output valid.
// A stall on out_ch holds the output register and freezes the counter.
module g3ruh_nrzi_shaped_modulator_top (
  input logic     clk,
  input logic     rst,
  g3r_in_if.sink  in_ch,
  g3r_out_if.source out_ch
);
  import g3r_pkg::*;

  // Working stage: remaining bits of the byte, sample counter, frame end flag.
  logic              busy;
  logic              busy_next;
  logic [BYTE_W-1:0] shreg;
  logic [BYTE_W-1:0] shreg_next;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  logic              last_byte;
  logic              last_byte_next;

  // Output register.
  logic                out_valid;
  logic                out_valid_next;
  logic [SAMPLE_W-1:0] out_sample;
  logic                out_run_last;
  logic                out_frame_done;

  logic          emit;
  logic          final_sample;
  logic          accept;
  logic          bit_edge;
  logic [2:0]    level_row;
  g3r_bit_ctrl_t bit_ctrl;

  // While busy, emit a sample whenever the output register is free or being drained.
  assign emit         = busy && (!out_valid || out_ch.ready);
  assign final_sample = (cnt == LAST_SAMPLE);
  assign in_ch.ready  = !busy || (emit && final_sample);
  assign accept       = in_ch.valid && in_ch.ready;
  // Advance to the next bit after its eighth sample, except at the byte end.
  assign bit_edge     = emit && (cnt[COL_W-1:0] == LAST_COL) && !final_sample;

  always_comb begin
    bit_ctrl = '0;
    if (accept) begin
      bit_ctrl.step     = 1'b1;
      bit_ctrl.seed     = in_ch.frame_start;
      bit_ctrl.data_bit = in_ch.data_byte[BYTE_W-1];
    end else if (bit_edge) begin
      bit_ctrl.step     = 1'b1;
      bit_ctrl.data_bit = shreg[BYTE_W-1];
    end
  end

  g3r_scrambler u_scrambler (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (bit_ctrl),
    .level_row (level_row)
  );

  always_comb begin
    busy_next      = busy;
    shreg_next     = shreg;
    cnt_next       = cnt;
    last_byte_next = last_byte;
    if (emit) begin
      cnt_next = cnt + 1'b1;
      if (final_sample) begin
        busy_next = 1'b0;
      end
    end
    if (bit_edge) begin
      shreg_next = {shreg[BYTE_W-2:0], 1'b0};
    end
    // Load a new byte: its first bit is already being stepped in.
    if (accept) begin
      busy_next      = 1'b1;
      shreg_next     = {in_ch.data_byte[BYTE_W-2:0], 1'b0};
      cnt_next       = '0;
      last_byte_next = in_ch.frame_last;
    end
  end

  always_comb begin
    out_valid_next = out_valid;
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      busy      <= busy_next;
      cnt       <= cnt_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    shreg     <= shreg_next;
    last_byte <= last_byte_next;
    if (emit) begin
      out_sample     <= shape_sample(level_row, cnt[COL_W-1:0]);
      out_run_last   <= final_sample;
      out_frame_done <= final_sample && last_byte;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.sample     = out_sample;
  assign out_ch.run_last   = out_run_last;
  assign out_ch.frame_done = out_frame_done;

endmodule

### sv/g3r_scrambler.sv
// G3RUH scrambler, NRZI line coder and three-level history for the shaping table.
module g3r_scrambler (
  input  logic                   clk,
  input  logic                   rst,
  input  g3r_pkg::g3r_bit_ctrl_t ctrl,
  output logic [2:0]             level_row
);
  import g3r_pkg::*;

  logic [HIST_W-1:0] history;
  logic [HIST_W-1:0] history_next;
  logic              old_bit;
  logic              old_bit_next;
  logic              level;
  logic              level_next;
  logic [ROW_W-1:0]  level_hist;
  logic [ROW_W-1:0]  level_hist_next;

  logic [HIST_W-1:0] hist_cur;
  logic              old_cur;
  logic              sent;

  always_comb begin
    hist_cur = ctrl.seed ? SEED_HISTORY : history;
    old_cur  = ctrl.seed ? SEED_OLD_BIT : old_bit;
    sent     = ctrl.data_bit ^ hist_cur[TAP_SHORT] ^ old_cur;

    history_next    = history;
    old_bit_next    = old_bit;
    level_next      = level;
    level_hist_next = level_hist;
    if (ctrl.step) begin
      old_bit_next    = hist_cur[TAP_LONG];
      history_next    = {hist_cur[HIST_W-2:0], sent};
      // A sent zero toggles the line level.
      level_next      = level ^ ~sent;
      level_hist_next = {level_hist[ROW_W-2:0], level ^ ~sent};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      history    <= SEED_HISTORY;
      old_bit    <= SEED_OLD_BIT;
      level      <= 1'b0;
      level_hist <= '0;
    end else begin
      history    <= history_next;
      old_bit    <= old_bit_next;
      level      <= level_next;
      level_hist <= level_hist_next;
    end
  end

  assign level_row = level_hist;

endmodule

### sv/g3r_checker.sv
// Port-level assertions for the modulator top, attached by bind.
module g3r_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_sample,
  input logic       out_run_last,
  input logic       out_frame_done
);

  // A byte occupies the block for 64 samples: no second byte straight after.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again in the cycle after a transaction");

  // Key release only ever comes on the last sample of a byte.
  a_done_on_run_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_frame_done) |-> out_run_last)
    else $error("frame_done without run_last");

  // An idle input stays free until a byte is offered.
  a_ready_while_idle: assert property (@(posedge clk) disable iff (rst)
    (in_ready && !in_valid) |=> in_ready)
    else $error("input ready dropped with no byte taken");

  // Stalled output holds its sample.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample)))
    else $error("output changed while stalled");

endmodule

bind g3ruh_nrzi_shaped_modulator_top g3r_checker u_g3r_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_sample     (out_ch.sample),
  .out_run_last   (out_ch.run_last),
  .out_frame_done (out_ch.frame_done)
);

### tb/g3r_modulator_checker.sv
// Checker for the G3RUH modulator: predicts the DAC sample stream and compares it.
`timescale 1ns / 100ps

module g3r_modulator_checker (
  input  logic clk,
  input  logic rst,
  g3r_in_if    byte_ch,
  g3r_out_if   sample_ch,
  output int   mismatch_count,
  output int   samples_due,
  output int   samples_checked
);
  import g3r_pkg::*;

  // Pulse shapes, one row per three-level pattern, oldest level in the top bit.
  localparam logic [SAMPLE_W-1:0] PULSE_ROWS [0:7][0:7] = '{
    '{8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0  },
    '{8'd0,   8'd0,   8'd0,   8'd2,   8'd6,   8'd18,  8'd42,  8'd80 },
    '{8'd127, 8'd175, 8'd212, 8'd235, 8'd243, 8'd235, 8'd212, 8'd175},
    '{8'd128, 8'd175, 8'd213, 8'd237, 8'd249, 8'd253, 8'd255, 8'd255},
    '{8'd127, 8'd80,  8'd42,  8'd18,  8'd6,   8'd2,   8'd0,   8'd0  },
    '{8'd128, 8'd80,  8'd43,  8'd20,  8'd12,  8'd20,  8'd43,  8'd80 },
    '{8'd255, 8'd255, 8'd255, 8'd253, 8'd249, 8'd237, 8'd213, 8'd175},
    '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}
  };

  typedef struct packed {
    logic [SAMPLE_W-1:0] level;
    logic                byte_end;
    logic                key_release;
  } dac_sample_t;

  logic [HIST_W-1:0] scr_bits;
  logic              scr_bit17;
  logic              line_level;
  logic [2:0]        level_trail;
  dac_sample_t       shaped_samples [$];

  // Scramble, NRZI-code and shape one byte into its 64 samples.
  task automatic modulate_byte(input logic [BYTE_W-1:0] data, input logic seed,
                               input logic last);
    logic        feedback;
    logic        sent;
    dac_sample_t s;
    if (seed) begin
      scr_bits  = SEED_HISTORY;
      scr_bit17 = SEED_OLD_BIT;
    end
    for (int b = BYTE_W - 1; b >= 0; b--) begin
      feedback  = scr_bits[TAP_SHORT] ^ scr_bit17;
      sent      = data[b] ^ feedback;
      scr_bit17 = scr_bits[TAP_LONG];
      scr_bits  = {scr_bits[HIST_W-2:0], sent};
      if (!sent) begin
        line_level = ~line_level;
      end
      level_trail = {level_trail[1:0], line_level};
      for (int c = 0; c < SAMPLES_PER_BIT; c++) begin
        s.level       = PULSE_ROWS[level_trail][c];
        s.byte_end    = (b == 0) && (c == SAMPLES_PER_BIT - 1);
        s.key_release = s.byte_end && last;
        shaped_samples.push_back(s);
      end
    end
  endtask

  task automatic note_fault(input string field, input int want, input int got);
    $display("%0t: sample %0d %s mismatch, expected %0d, actual %0d",
             $time, samples_checked, field, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    dac_sample_t want;
    if (rst) begin
      scr_bits    = SEED_HISTORY;
      scr_bit17   = SEED_OLD_BIT;
      line_level  = 1'b0;
      level_trail = 3'd0;
      shaped_samples.delete();
    end else begin
      // Pop before push, so a sample cannot be matched to a byte taken in the same cycle.
      if (sample_ch.valid && sample_ch.ready) begin
        if (shaped_samples.size() == 0) begin
          $display("%0t: unexpected sample %0d, expected none, actual %0d",
                   $time, samples_checked, sample_ch.sample);
          mismatch_count++;
        end else begin
          want = shaped_samples.pop_front();
          if (sample_ch.sample !== want.level) begin
            note_fault("sample", want.level, sample_ch.sample);
          end
          if (sample_ch.run_last !== want.byte_end) begin
            note_fault("run_last", want.byte_end, sample_ch.run_last);
          end
          if (sample_ch.frame_done !== want.key_release) begin
            note_fault("frame_done", want.key_release, sample_ch.frame_done);
          end
        end
        samples_checked++;
      end
      if (byte_ch.valid && byte_ch.ready) begin
        modulate_byte(byte_ch.data_byte, byte_ch.frame_start, byte_ch.frame_last);
      end
    end
    samples_due = shaped_samples.size();
  end

endmodule

### tb/tb_g3ruh_nrzi_shaped_modulator_top.sv
// Testbench top for the G3RUH modulator: stimulus, output back-pressure and verdict.
`timescale 1ns / 100ps

module tb_g3ruh_nrzi_shaped_modulator_top;
  import g3r_pkg::*;

  localparam logic [BYTE_W-1:0] HDLC_FLAG = 8'h7E;
  localparam int ITEM_TARGET    = 200;   // directed plus random bytes
  localparam int HOLD_AT_SAMPLE = 1000;  // when the receiver starts its long hold-off
  localparam int HOLD_CYCLES    = 500;
  localparam int IDLE_LIMIT     = 5000;  // cycles with no transaction on either channel
  localparam int DRAIN_CYCLES   = 80;    // a little over one byte of samples

  // Opening sequence, each entry {data_byte, frame_start, frame_last}.
  localparam int OPENING_LEN = 21;
  localparam logic [BYTE_W+1:0] OPENING [0:OPENING_LEN-1] = '{
    {8'h00, 1'b1, 1'b0},  // seed at the very first byte
    {8'hFF, 1'b0, 1'b0},
    {HDLC_FLAG, 1'b0, 1'b0},
    {HDLC_FLAG, 1'b0, 1'b0},
    {8'h80, 1'b0, 1'b0},
    {8'h01, 1'b0, 1'b0},
    {8'hAA, 1'b0, 1'b0},
    {8'h55, 1'b0, 1'b1},  // close the first frame
    {HDLC_FLAG, 1'b1, 1'b1},  // one-byte frame: start and last together
    {8'hFF, 1'b0, 1'b0},  // carry on without a reseed
    {8'h00, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b0},
    {8'hFF, 1'b1, 1'b0},  // reseed mid-stream, line level must carry over
    {8'h0F, 1'b0, 1'b0},
    {8'hF0, 1'b0, 1'b1},
    {HDLC_FLAG, 1'b0, 1'b1},  // last flag twice in a row
    {8'hFF, 1'b1, 1'b0},  // long run of ones
    {8'hFF, 1'b0, 1'b0},
    {8'hFF, 1'b0, 1'b0},
    {8'hFF, 1'b0, 1'b0},
    {8'h00, 1'b0, 1'b1}
  };

  logic clk = 1'b0;
  logic rst;

  g3r_in_if  byte_ch ();
  g3r_out_if sample_ch ();

  int mismatch_count;
  int samples_due;
  int samples_checked;
  int bytes_sent;
  int frames_closed;
  int idle_cycles;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  g3ruh_nrzi_shaped_modulator_top u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (byte_ch),
    .out_ch (sample_ch)
  );

  g3r_modulator_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .byte_ch         (byte_ch),
    .sample_ch       (sample_ch),
    .mismatch_count  (mismatch_count),
    .samples_due     (samples_due),
    .samples_checked (samples_checked)
  );

  // Offer one byte. Call at a falling edge; return at the falling edge after the
  // transaction. Valid is only dropped when a gap is drawn, so a back-to-back byte
  // never sees valid lowered and raised in the same step.
  task automatic send_byte(input logic [BYTE_W-1:0] data, input logic seed,
                           input logic last);
    int gap;
    gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      byte_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    byte_ch.valid       <= 1'b1;
    byte_ch.data_byte   <= data;
    byte_ch.frame_start <= seed;
    byte_ch.frame_last  <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    if (last) begin
      frames_closed++;
    end
  endtask

  // Stimulus: opening sequence, then mostly well-formed frames with some noise.
  initial begin : byte_source
    int kind;
    int n_flags;
    int n_body;
    rst                 = 1'b1;
    byte_ch.valid       = 1'b0;
    byte_ch.data_byte   = '0;
    byte_ch.frame_start = 1'b0;
    byte_ch.frame_last  = 1'b0;
    bytes_sent          = 0;
    frames_closed       = 0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < OPENING_LEN; i++) begin
      send_byte(OPENING[i][BYTE_W+1:2], OPENING[i][1], OPENING[i][0]);
    end

    while (bytes_sent < ITEM_TARGET) begin
      kind = $urandom_range(0, 9);
      if (kind < 8) begin
        // Frame: flag preamble with the reseed on its first flag, random body,
        // last flag on the final body byte.
        n_flags = $urandom_range(1, 4);
        n_body  = $urandom_range(1, 10);
        for (int i = 0; i < n_flags; i++) begin
          send_byte(HDLC_FLAG, i == 0, 1'b0);
        end
        for (int i = 0; i < n_body; i++) begin
          send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, i == n_body - 1);
        end
      end else begin
        // Noise: random bytes with random frame flags.
        repeat ($urandom_range(1, 6)) begin
          send_byte(BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end
    end
    byte_ch.valid <= 1'b0;

    // Drain: wait for every predicted sample, then a little longer for strays.
    while (samples_due != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Run covered %0d bytes with %0d frame ends, %0d samples compared.",
             bytes_sent, frames_closed, samples_checked);
    $display("Mismatches: %0d, samples still awaited: %0d.", mismatch_count, samples_due);
    if (mismatch_count == 0 && samples_due == 0) begin
      $display("** g3ruh_nrzi_shaped_modulator_top: PASSED **");
    end else begin
      $display("** g3ruh_nrzi_shaped_modulator_top: FAILED **");
    end
    $finish;
  end

  // Sample receiver: per-sample stall drawn from a mode chosen every 64 samples,
  // so there are calm stretches, sparse stalls and heavy stalls. Once, hold ready
  // low for a long stretch so the block fills and pushes back on the byte side.
  initial begin : sample_sink
    int gap;
    int taken;
    int mode;
    sample_ch.ready = 1'b0;
    taken           = 0;
    mode            = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % SAMPLES_PER_BYTE == 0) begin
        mode = $urandom_range(0, 2);
      end
      case (mode)
        0: gap = 0;
        1: gap = $urandom_range(0, 19);
        default: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
      endcase
      if (taken == HOLD_AT_SAMPLE) begin
        gap = HOLD_CYCLES;
      end
      if (gap > 0) begin
        sample_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      sample_ch.ready <= 1'b1;
      @(posedge clk);
      while (!sample_ch.valid) @(posedge clk);
      @(negedge clk);
      taken++;
    end
  end

  // Watchdog: end the run if neither channel moves a transaction for too long.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((byte_ch.valid && byte_ch.ready) || (sample_ch.valid && sample_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, samples awaited %0d",
               $time, idle_cycles, samples_due);
      $display("** g3ruh_nrzi_shaped_modulator_top: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### sim.f
sv/g3r_pkg.sv
sv/g3r_if.sv
sv/g3r_scrambler.sv
sv/g3ruh_nrzi_shaped_modulator_top.sv
sv/g3r_checker.sv
tb/g3r_modulator_checker.sv
tb/tb_g3ruh_nrzi_shaped_modulator_top.sv
